FILE: hw/rtl/rau_pkg.sv
package rau_pkg;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_DIV = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] res_num;
    logic [61:0]        res_den;
    logic [1:0]         status;
  } out_item_t;

  // classified job handed from front to back
  typedef struct packed {
    logic        neg;
    logic [62:0] mag;
    logic [61:0] den;
    logic [1:0]  status;
  } job_t;

endpackage

FILE: hw/rtl/rau_front.sv
module rau_front #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rau_pkg::in_item_t in_data,
  input  logic              in_push,
  output logic              in_full,
  output rau_pkg::job_t     job,
  output logic              job_valid,
  input  logic              job_ready
);
  import rau_pkg::*;

  localparam int W = OPERAND_WIDTH;

  typedef enum logic [2:0] {S_IDLE, S_MUL1, S_MUL2, S_SUM, S_OUT} state_t;

  state_t state_r;
  logic [1:0] act_r;
  logic signed [W-1:0] an_r, ad_r, bn_r, bd_r;
  logic signed [63:0] p0_r, p1_r;
  logic signed [63:0] num_r;
  logic [61:0] den_r;
  logic [1:0] st_r;
  logic short_r;

  function automatic logic signed [W-1:0] take(input logic [31:0] raw);
    logic signed [W-1:0] v;
    v = raw[W-1:0];
    if (v == {1'b1, {(W-1){1'b0}}}) v = {1'b1, {(W-2){1'b0}}, 1'b1};
    return v;
  endfunction

  logic signed [W-1:0] an_i, ad_i, bn_i, bd_i;
  always_comb begin
    an_i = take(in_data.a_num);
    ad_i = take(in_data.a_den);
    bn_i = take(in_data.b_num);
    bd_i = take(in_data.b_den);
  end

  // b with its denominator made positive; divide then moves the sign of b_num onto b_den
  logic signed [W-1:0] bn_f, bd_f;
  logic div_flip;
  always_comb begin
    bn_f = bd_i[W-1] ? -bn_i : bn_i;
    bd_f = bd_i[W-1] ? -bd_i : bd_i;
    div_flip = (action_t'(in_data.action) == ACT_DIV) && (bn_f < 0);
  end

  assign in_full = (state_r != S_IDLE);
  assign job_valid = (state_r == S_OUT);

  logic signed [63:0] m0, m1;
  always_comb begin
    m0 = '0;
    m1 = '0;
    case (action_t'(act_r))
      ACT_MUL: begin
        m0 = 64'(an_r) * 64'(bn_r);
        m1 = 64'(ad_r) * 64'(bd_r);
      end
      ACT_DIV: begin
        m0 = 64'(an_r) * 64'(bd_r);
        m1 = 64'(ad_r) * 64'(bn_r);
      end
      default: begin
        m0 = 64'(an_r) * 64'(bd_r);
        m1 = 64'(ad_r) * 64'(bn_r);
      end
    endcase
  end

  logic signed [63:0] dd;
  assign dd = 64'(ad_r) * 64'(bd_r);

  logic [63:0] nabs;
  assign nabs = num_r[63] ? 64'(-num_r) : 64'(num_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: if (in_push) begin
          act_r <= in_data.action;
          short_r <= 1'b0;
          st_r <= ST_OK;
          if (ad_i == '0 || bd_i == '0) begin
            short_r <= 1'b1;
            st_r <= ST_ZERO_DEN;
          end else if (action_t'(in_data.action) == ACT_DIV && bn_i == '0) begin
            short_r <= 1'b1;
            st_r <= ST_DIV_ZERO;
          end
          an_r <= ad_i[W-1] ? -an_i : an_i;
          ad_r <= ad_i[W-1] ? -ad_i : ad_i;
          bn_r <= div_flip ? -bn_f : bn_f;
          bd_r <= div_flip ? -bd_f : bd_f;
          state_r <= S_MUL1;
        end
        S_MUL1: begin
          p0_r <= m0;
          p1_r <= m1;
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          case (action_t'(act_r))
            ACT_ADD: begin num_r <= p0_r + p1_r; den_r <= 62'(dd); end
            ACT_SUB: begin num_r <= p0_r - p1_r; den_r <= 62'(dd); end
            ACT_MUL: begin num_r <= p0_r; den_r <= 62'(p1_r); end
            default: begin num_r <= p0_r; den_r <= 62'(p1_r); end
          endcase
          state_r <= S_SUM;
        end
        S_SUM: begin
          if (short_r || num_r == '0) begin
            job.neg <= 1'b0;
            job.mag <= '0;
            job.den <= 62'd1;
          end else begin
            job.neg <= num_r[63];
            job.mag <= nabs[62:0];
            job.den <= den_r;
          end
          job.status <= st_r;
          state_r <= S_OUT;
        end
        S_OUT: if (job_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: hw/rtl/rau_back.sv
module rau_back (
  input  logic               clk,
  input  logic               rst_n,
  input  rau_pkg::job_t      job,
  input  logic               job_valid,
  output logic               job_ready,
  output rau_pkg::out_item_t out_data,
  output logic               out_empty,
  input  logic               out_pop
);
  import rau_pkg::*;

  typedef enum logic [2:0] {B_IDLE, B_GCD, B_DIV, B_FIN, B_OUT} state_t;

  state_t state_r;
  job_t j_r;
  logic [62:0] x_r, y_r;
  logic [6:0] k_r;
  // restoring division state, shared for numerator then denominator
  logic [62:0] q_r, rem_r, dvd_r;
  logic [6:0] cnt_r;
  logic which_r;
  logic [62:0] qn_r;

  assign job_ready = (state_r == B_IDLE);
  assign out_empty = (state_r != B_OUT);

  logic [63:0] trial;
  assign trial = {rem_r, dvd_r[62]} - {1'b0, x_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      case (state_r)
        B_IDLE: if (job_valid) begin
          j_r <= job;
          x_r <= job.mag;
          y_r <= {1'b0, job.den};
          k_r <= '0;
          state_r <= (job.mag == '0) ? B_FIN : B_GCD;
        end
        B_GCD: begin
          // binary gcd, one step a cycle; result left in x_r << k_r
          if (y_r == '0) begin
            x_r <= x_r << k_r;
            dvd_r <= j_r.mag;
            rem_r <= '0;
            q_r <= '0;
            cnt_r <= '0;
            which_r <= 1'b0;
            state_r <= B_DIV;
          end else if (!x_r[0] && !y_r[0]) begin
            x_r <= x_r >> 1; y_r <= y_r >> 1; k_r <= k_r + 7'd1;
          end else if (!x_r[0]) x_r <= x_r >> 1;
          else if (!y_r[0]) y_r <= y_r >> 1;
          else if (x_r >= y_r) begin
            x_r <= y_r; y_r <= (x_r - y_r) >> 1;
          end else y_r <= (y_r - x_r) >> 1;
        end
        B_DIV: begin
          if (!trial[63]) begin
            rem_r <= trial[62:0];
            q_r <= {q_r[61:0], 1'b1};
          end else begin
            rem_r <= {rem_r[61:0], dvd_r[62]};
            q_r <= {q_r[61:0], 1'b0};
          end
          dvd_r <= dvd_r << 1;
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'd62) begin
            if (!which_r) begin
              qn_r <= !trial[63] ? {q_r[61:0], 1'b1} : {q_r[61:0], 1'b0};
              which_r <= 1'b1;
              dvd_r <= {1'b0, j_r.den};
              rem_r <= '0;
              q_r <= '0;
              cnt_r <= '0;
            end else begin
              out_data.res_num <= j_r.neg ? -$signed({1'b0, qn_r}) : $signed({1'b0, qn_r});
              out_data.res_den <= !trial[63] ? {q_r[60:0], 1'b1} : {q_r[60:0], 1'b0};
              out_data.status <= j_r.status;
              state_r <= B_OUT;
            end
          end
        end
        B_FIN: begin
          out_data.res_num <= '0;
          out_data.res_den <= 62'd1;
          out_data.status <= j_r.status;
          state_r <= B_OUT;
        end
        B_OUT: if (out_pop) state_r <= B_IDLE;
        default: state_r <= B_IDLE;
      endcase
    end
  end
endmodule

FILE: hw/rtl/rational_arithmetic_unit.sv
// a zero or error result skips the gcd and both divides; any other result runs the gcd, then two 63-step divides
// front and back overlap via a job register, so the front can take a new item while the back works on the last
// front: clamp, sign fix, two multiply stages; back: binary gcd then restoring divider
// rst_n is synchronous, active low; it empties both halves, no pending result survives
module rational_arithmetic_unit #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  rau_pkg::in_item_t  in_data,
  output logic               out_empty,
  input  logic               out_pop,
  output rau_pkg::out_item_t out_data
);
  import rau_pkg::*;

  job_t job;
  logic job_valid, job_ready;

  rau_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
    .clk, .rst_n, .in_data, .in_push, .in_full,
    .job, .job_valid, .job_ready
  );

  rau_back u_back (
    .clk, .rst_n, .job, .job_valid, .job_ready,
    .out_data, .out_empty, .out_pop
  );
endmodule
